>>> hdl/bae_pkg.sv
// Shared types, codes and step tables for the button auto-repeat encoder.
`default_nettype none
package bae_pkg;

  localparam int unsigned LEVELS = 5;  // hold levels above zero
  localparam int unsigned MULT_W = 35; // hold_step_us * 5 fits in 35 bits

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int unsigned CFG_REVERSE   = 0;
  localparam int unsigned CFG_HOLD_STEP = 1;

  localparam logic [31:0] HOLD_STEP_RST = 32'd1000000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_us;
    logic        up_pin_level;
    logic        down_pin_level;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] change;
    logic [1:0]         mode;
    logic signed [31:0] position;
  } out_item_t;

  // Config as seen by the datapath: multiples 1..5 of the hold step.
  typedef struct packed {
    logic                          reverse;
    logic [LEVELS-1:0][MULT_W-1:0] hold_mult;
  } cfg_t;

  function automatic logic [17:0] step_rate(input logic [2:0] lvl);
    logic [17:0] r;
    case (lvl)
      3'd0:    r = 18'd200000;
      3'd1:    r = 18'd100000;
      3'd2:    r = 18'd50000;
      default: r = 18'd20000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] step_size(input logic [2:0] lvl);
    logic [2:0] s;
    case (lvl)
      3'd4:    s = 3'd2;
      3'd5:    s = 3'd4;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/button_autorepeat_encoder_top.sv
// Top level: input register, update core, result register and handshakes.
// An accepted item waits in the input register, then goes to the result register.
// Throughput: one item per cycle unless out_stall holds a full result register.
// in_stall rises only while the result register is full and out_stall is high.
// Synchronous active-low reset clears the pipeline, the button state,
// the position counters and the config (reverse off, hold step 1000000 us).
`default_nettype none
module button_autorepeat_encoder_top
  import bae_pkg::*;
#(
  parameter int unsigned CFG_IDX_W = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic      in_vld_r, out_vld_r;
  in_item_t  in_item_r;
  out_item_t out_item_r, result;
  cfg_t      cfg;
  logic      advance, in_take;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  bae_cfg #(.CFG_IDX_W(CFG_IDX_W)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bae_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> hdl/bae_cfg.sv
// Configuration registers, holding precomputed multiples of the hold step.
`default_nettype none
module bae_cfg
  import bae_pkg::*;
#(
  parameter int unsigned CFG_IDX_W = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output cfg_t                      cfg
);

  function automatic logic [LEVELS-1:0][MULT_W-1:0] mults(input logic [31:0] d);
    logic [LEVELS-1:0][MULT_W-1:0] m;
    logic [MULT_W-1:0]             dx;
    dx   = MULT_W'(d);
    m[0] = dx;
    m[1] = dx << 1;
    m[2] = dx + (dx << 1);
    m[3] = dx << 2;
    m[4] = dx + (dx << 2);
    return m;
  endfunction

  logic                          reverse_r;
  logic [LEVELS-1:0][MULT_W-1:0] hold_mult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r   <= 1'b0;
      hold_mult_r <= mults(HOLD_STEP_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_W'(CFG_REVERSE)) begin
        reverse_r <= cfg_data[0];
      end
      if (cfg_index == CFG_IDX_W'(CFG_HOLD_STEP)) begin
        hold_mult_r <= mults(cfg_data);
      end
    end
  end

  assign cfg.reverse   = reverse_r;
  assign cfg.hold_mult = hold_mult_r;

endmodule
`default_nettype wire

>>> hdl/bae_core.sv
// Button state, position tracking and the per-item update.
`default_nettype none
module bae_core
  import bae_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [1:0]  held_mode_r, held_mode_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] last_step_r, last_step_nxt;
  logic [31:0] position_r, position_nxt;
  logic [31:0] read_pos_r, read_pos_nxt;

  logic [31:0]       elapsed, since_step, diff, step;
  logic [LEVELS-1:0] past_mult;
  logic [2:0]        lvl;
  logic              step_due, pin;
  logic [31:0]       change;

  // Hold level = number of hold-step multiples already passed, so at most 5
  always_comb begin
    elapsed = item.now_us - press_start_r;
    for (int k = 0; k < LEVELS; k++) begin
      past_mult[k] = MULT_W'(elapsed) >= cfg.hold_mult[k];
    end
    lvl = 3'(past_mult[0]) + 3'(past_mult[1]) + 3'(past_mult[2])
        + 3'(past_mult[3]) + 3'(past_mult[4]);
    since_step = item.now_us - last_step_r;
    step_due   = since_step > 32'(step_rate(lvl));
    step       = 32'(step_size(lvl));
    diff       = position_r - read_pos_r;
  end

  always_comb begin
    held_mode_nxt   = held_mode_r;
    press_start_nxt = press_start_r;
    last_step_nxt   = last_step_r;
    position_nxt    = position_r;
    read_pos_nxt    = read_pos_r;
    change          = '0;
    pin             = 1'b1;
    if (item.cmd == CMD_READ) begin
      change       = cfg.reverse ? (32'd0 - diff) : diff;
      read_pos_nxt = position_r;
    end else begin
      unique case (held_mode_r)
        MODE_UP, MODE_DOWN: begin
          pin = (held_mode_r == MODE_UP) ? item.up_pin_level : item.down_pin_level;
          if (pin) begin
            held_mode_nxt = MODE_IDLE;
          end else if (step_due) begin
            position_nxt  = (held_mode_r == MODE_UP) ? position_r + step
                                                     : position_r - step;
            last_step_nxt = item.now_us;
          end
        end
        default: begin
          // idle (and the unused code): up wins over down
          held_mode_nxt = MODE_IDLE;
          if (!item.up_pin_level) begin
            press_start_nxt = item.now_us;
            last_step_nxt   = item.now_us;
            held_mode_nxt   = MODE_UP;
            position_nxt    = position_r + 32'd1;
          end else if (!item.down_pin_level) begin
            press_start_nxt = item.now_us;
            last_step_nxt   = item.now_us;
            held_mode_nxt   = MODE_DOWN;
            position_nxt    = position_r - 32'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mode_r   <= MODE_IDLE;
      press_start_r <= '0;
      last_step_r   <= '0;
      position_r    <= '0;
      read_pos_r    <= '0;
    end else if (go) begin
      held_mode_r   <= held_mode_nxt;
      press_start_r <= press_start_nxt;
      last_step_r   <= last_step_nxt;
      position_r    <= position_nxt;
      read_pos_r    <= read_pos_nxt;
    end
  end

  assign result.change   = change;
  assign result.mode     = held_mode_nxt;
  assign result.position = position_nxt;

`ifndef ASSERT_OFF
  a_read_syncs: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.cmd == CMD_READ |=> read_pos_r == $past(position_r))
    else $error("read item did not catch up read position");

  a_read_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.cmd == CMD_READ |=> $stable(position_r) && $stable(held_mode_r))
    else $error("read item disturbed button state");

  a_sample_keeps_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && item.cmd == CMD_READ) |=> $stable(read_pos_r))
    else $error("read position moved without a read item");

  a_press_up: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.cmd == CMD_SAMPLE && held_mode_r == MODE_IDLE && !item.up_pin_level
    |=> held_mode_r == MODE_UP && position_r == $past(position_r) + 32'd1)
    else $error("up press from idle did not step by one");
`endif

endmodule
`default_nettype wire
